>>> design/m65_pkg.sv
package m65_pkg;

  localparam logic [3:0] ST_BOOT = 4'd0;
  localparam logic [3:0] ST_VLO  = 4'd1;
  localparam logic [3:0] ST_VHI  = 4'd2;
  localparam logic [3:0] ST_OPC  = 4'd3;
  localparam logic [3:0] ST_OP1  = 4'd4;
  localparam logic [3:0] ST_OP2  = 4'd5;
  localparam logic [3:0] ST_PLO  = 4'd6;
  localparam logic [3:0] ST_PHI  = 4'd7;
  localparam logic [3:0] ST_DATA = 4'd8;
  localparam logic [3:0] ST_WEND = 4'd9;
  localparam logic [3:0] ST_PUSH = 4'd10;
  localparam logic [3:0] ST_POP  = 4'd11;
  localparam logic [3:0] ST_HALT = 4'd12;
  localparam logic [3:0] ST_PAD  = 4'd13;

  typedef enum logic [3:0] {
    M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY,
    M_IND, M_JMP, M_JSR, M_REL
  } mode_t;

  localparam logic [1:0] K_BRK = 2'd0;
  localparam logic [1:0] K_IRQ = 2'd1;
  localparam logic [1:0] K_NMI = 2'd2;
  localparam logic [1:0] K_JSR = 2'd3;

  localparam logic [7:0] PF_C = 8'h01;
  localparam logic [7:0] PF_Z = 8'h02;
  localparam logic [7:0] PF_I = 8'h04;
  localparam logic [7:0] PF_D = 8'h08;
  localparam logic [7:0] PF_B = 8'h10;
  localparam logic [7:0] PF_V = 8'h40;
  localparam logic [7:0] PF_N = 8'h80;

  localparam logic [7:0]  SP_RESET = 8'hFD;
  localparam logic [7:0]  P_RESET  = 8'h34;
  localparam logic [15:0] STACK_BASE = 16'h0100;

  function automatic logic is_legal(input logic [7:0] op);
    logic [15:0] row;
    begin
      case (op[7:4])
        4'h0: row = 16'h6763;
        4'h2: row = 16'h7773;
        4'h4, 4'h6: row = 16'h7763;
        4'h8: row = 16'h7572;
        4'h9: row = 16'h2773;
        4'hA: row = 16'h7777;
        4'hB, 4'hC, 4'hE: row = 16'h7773;
        default: row = 16'h6363;
      endcase
      is_legal = row[op[3:0]];
    end
  endfunction

  function automatic mode_t addr_mode(input logic [7:0] op);
    mode_t m;
    begin
      if (op == 8'h20) m = M_JSR;
      else if (op == 8'h4C) m = M_JMP;
      else if (op == 8'h6C) m = M_IND;
      else if (op[4:0] == 5'h10) m = M_REL;
      else if (op[1:0] == 2'd1) begin
        case (op[4:2])
          3'd0: m = M_IZX;
          3'd1: m = M_ZP;
          3'd2: m = M_IMM;
          3'd3: m = M_ABS;
          3'd4: m = M_IZY;
          3'd5: m = M_ZPX;
          3'd6: m = M_ABY;
          default: m = M_ABX;
        endcase
      end else if (op == 8'h96 || op == 8'hB6) m = M_ZPY;
      else if (op == 8'hBE) m = M_ABY;
      else begin
        case (op[4:2])
          3'd0: m = M_IMM;
          3'd1: m = M_ZP;
          3'd3: m = M_ABS;
          3'd5: m = M_ZPX;
          default: m = M_ABX;
        endcase
      end
      addr_mode = m;
    end
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    set_nz = {v[7], p[6:2], (v == 8'd0), p[0]};
  endfunction

  // shift / inc / dec, returns {flags, result}
  function automatic logic [15:0] shift_op(input logic [2:0] kind, input logic [7:0] v,
                                           input logic [7:0] p);
    logic [7:0] r;
    logic nc;
    begin
      nc = p[0];
      case (kind)
        3'd0: begin r = {v[6:0], 1'b0}; nc = v[7]; end
        3'd1: begin r = {v[6:0], p[0]}; nc = v[7]; end
        3'd2: begin r = {1'b0, v[7:1]}; nc = v[0]; end
        3'd3: begin r = {p[0], v[7:1]}; nc = v[0]; end
        3'd6: r = v - 8'd1;
        default: r = v + 8'd1;
      endcase
      shift_op = {set_nz({p[7:1], nc}, r), r};
    end
  endfunction

endpackage

>>> design/m65_alu.sv
module m65_alu import m65_pkg::*; (
  input  logic [7:0] op,
  input  logic [7:0] v,
  input  logic [7:0] a_in,
  input  logic [7:0] x_in,
  input  logic [7:0] y_in,
  input  logic [7:0] p_in,
  output logic [7:0] a_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] p_out
);

  logic [8:0] sum;
  logic [8:0] diff;
  logic [8:0] cmp;
  logic [7:0] cref;

  always_comb begin
    a_out = a_in;
    x_out = x_in;
    y_out = y_in;
    p_out = p_in;
    sum = {1'b0, a_in} + {1'b0, v} + {8'd0, p_in[0]};
    diff = {1'b0, a_in} - {1'b0, v} - {8'd0, ~p_in[0]};
    cref = (op[1:0] == 2'd1) ? a_in : ((op[7:5] == 3'd6) ? y_in : x_in);
    cmp = {1'b0, cref} - {1'b0, v};
    if (op[1:0] == 2'd1) begin
      case (op[7:5])
        3'd0: begin a_out = a_in | v; p_out = set_nz(p_in, a_in | v); end
        3'd1: begin a_out = a_in & v; p_out = set_nz(p_in, a_in & v); end
        3'd2: begin a_out = a_in ^ v; p_out = set_nz(p_in, a_in ^ v); end
        3'd3: begin
          a_out = sum[7:0];
          p_out = set_nz({p_in[7], (~(a_in[7] ^ v[7])) & (a_in[7] ^ sum[7]), p_in[5:1],
                          sum[8]}, sum[7:0]);
        end
        3'd5: begin a_out = v; p_out = set_nz(p_in, v); end
        3'd6: p_out = set_nz({p_in[7:1], ~cmp[8]}, cmp[7:0]);
        3'd7: begin
          a_out = diff[7:0];
          p_out = set_nz({p_in[7], (a_in[7] ^ diff[7]) & (a_in[7] ^ v[7]), p_in[5:1],
                          ~diff[8]}, diff[7:0]);
        end
        default: ;
      endcase
    end else if (op[1:0] == 2'd2) begin
      if (op[7:5] == 3'd5) begin x_out = v; p_out = set_nz(p_in, v); end
    end else begin
      case (op[7:5])
        3'd1: p_out = {v[7:6], p_in[5:2], ((a_in & v) == 8'd0), p_in[0]};
        3'd5: begin y_out = v; p_out = set_nz(p_in, v); end
        3'd6, 3'd7: p_out = set_nz({p_in[7:1], ~cmp[8]}, cmp[7:0]);
        default: ;
      endcase
    end
  end

endmodule

>>> design/mos6502_instruction_core.sv
// 6502 core in binary mode: each request carries the byte read by the previous bus
// access plus irq/nmi, and yields the next bus access. One request per clock is
// accepted while the result is not stalled, and its result is valid the cycle after;
// the result register is refilled in the same cycle it is taken, and a stalled
// result holds while a new request waits. Reset fetches the vector at fffc.
module mos6502_instruction_core import m65_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  read_data,
  input  logic        irq_line,
  input  logic        nmi_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] bus_address,
  output logic        bus_write,
  output logic [7:0]  write_data,
  output logic        instruction_start,
  output logic        halted
);

  logic [7:0] a, x, y, sp, p, opc, latch;
  logic [15:0] pc, oaddr;
  logic [3:0] step;
  logic nmi_pend, stopped;
  logic [1:0] seq_kind, seq_count;

  logic [7:0] a_next, x_next, y_next, sp_next, p_next, opc_next, latch_next;
  logic [15:0] pc_next, oaddr_next;
  logic [3:0] step_next;
  logic nmi_next, stopped_next;
  logic [1:0] kind_next, count_next;
  logic [15:0] o_addr;
  logic o_we, o_start;
  logic [7:0] o_data;

  logic [7:0] alu_a, alu_x, alu_y, alu_p;
  logic accept;

  assign in_stall = out_valid & out_stall;
  assign accept = in_valid & ~in_stall;

  m65_alu u_alu (
    .op(opc), .v(read_data), .a_in(a), .x_in(x), .y_in(y), .p_in(p),
    .a_out(alu_a), .x_out(alu_x), .y_out(alu_y), .p_out(alu_p)
  );

  always_comb begin
    logic [7:0] d, pv;
    logic [15:0] full, sh, acc_addr;
    mode_t md;
    logic do_access, do_boundary, do_push, tst;
    a_next = a; x_next = x; y_next = y; sp_next = sp; p_next = p; opc_next = opc;
    latch_next = latch; pc_next = pc; oaddr_next = oaddr; step_next = step;
    nmi_next = nmi_pend | (~stopped & nmi_request);
    stopped_next = stopped; kind_next = seq_kind; count_next = seq_count;
    o_addr = 16'd0; o_we = 1'b0; o_data = 8'd0; o_start = 1'b0;
    d = read_data;
    md = addr_mode(opc);
    full = {d, latch};
    acc_addr = 16'd0;
    do_access = 1'b0;
    do_boundary = 1'b0;
    do_push = 1'b0;
    pv = 8'd0;
    sh = 16'd0;
    tst = 1'b0;
    unique case (step)
      ST_BOOT: begin
        oaddr_next = 16'hFFFC; o_addr = 16'hFFFC; step_next = ST_VLO;
      end
      ST_VLO: begin
        pc_next = {pc[15:8], d}; o_addr = oaddr + 16'd1; step_next = ST_VHI;
      end
      ST_VHI: begin
        pc_next = {d, pc[7:0]}; o_addr = {d, pc[7:0]}; o_start = 1'b1; step_next = ST_OPC;
      end
      ST_OPC: begin
        opc_next = d;
        pc_next = pc + 16'd1;
        if (!is_legal(d)) begin
          stopped_next = 1'b1; o_addr = pc + 16'd1; step_next = ST_HALT;
        end else if (d == 8'h00) begin
          o_addr = pc + 16'd1; pc_next = pc + 16'd2; step_next = ST_PAD;
        end else if (d == 8'h28 || d == 8'h40 || d == 8'h60 || d == 8'h68) begin
          count_next = 2'd0; sp_next = sp + 8'd1;
          o_addr = STACK_BASE | {8'd0, sp + 8'd1}; step_next = ST_POP;
        end else if (d == 8'h08 || d == 8'h48) begin
          pv = (d == 8'h08) ? (p | 8'h30) : a;
          o_addr = STACK_BASE | {8'd0, sp}; o_we = 1'b1; o_data = pv;
          sp_next = sp - 8'd1; step_next = ST_WEND;
        end else if (d[3:0] == 4'h8 || d[3:0] == 4'hA) begin
          do_boundary = 1'b1;
          case (d)
            8'h18: p_next = p & ~PF_C;
            8'h38: p_next = p | PF_C;
            8'h58: p_next = p & ~PF_I;
            8'h78: p_next = p | PF_I;
            8'hB8: p_next = p & ~PF_V;
            8'hD8: p_next = p & ~PF_D;
            8'hF8: p_next = p | PF_D;
            8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
              sh = shift_op(d[7:5], a, p); a_next = sh[7:0]; p_next = sh[15:8];
            end
            8'h88: begin y_next = y - 8'd1; p_next = set_nz(p, y - 8'd1); end
            8'hC8: begin y_next = y + 8'd1; p_next = set_nz(p, y + 8'd1); end
            8'hCA: begin x_next = x - 8'd1; p_next = set_nz(p, x - 8'd1); end
            8'hE8: begin x_next = x + 8'd1; p_next = set_nz(p, x + 8'd1); end
            8'h8A: begin a_next = x; p_next = set_nz(p, x); end
            8'h98: begin a_next = y; p_next = set_nz(p, y); end
            8'hAA: begin x_next = a; p_next = set_nz(p, a); end
            8'hA8: begin y_next = a; p_next = set_nz(p, a); end
            8'hBA: begin x_next = sp; p_next = set_nz(p, sp); end
            8'h9A: sp_next = x;
            default: ;
          endcase
        end else begin
          md = addr_mode(d);
          o_addr = pc + 16'd1;
          pc_next = pc + 16'd2;
          if (md == M_IMM || md == M_REL) begin
            oaddr_next = pc + 16'd1; step_next = ST_DATA;
          end else begin
            step_next = ST_OP1;
          end
        end
      end
      ST_OP1: begin
        if (md == M_ZP) begin do_access = 1'b1; acc_addr = {8'd0, d}; end
        else if (md == M_ZPX) begin do_access = 1'b1; acc_addr = {8'd0, d + x}; end
        else if (md == M_ZPY) begin do_access = 1'b1; acc_addr = {8'd0, d + y}; end
        else if (md == M_IZX || md == M_IZY) begin
          oaddr_next = {8'd0, (md == M_IZX) ? d + x : d};
          o_addr = oaddr_next; step_next = ST_PLO;
        end else begin
          latch_next = d; o_addr = pc; pc_next = pc + 16'd1; step_next = ST_OP2;
        end
      end
      ST_OP2: begin
        if (md == M_JMP) begin pc_next = full; do_boundary = 1'b1; end
        else if (md == M_JSR) begin
          oaddr_next = full; pc_next = pc - 16'd1;
          kind_next = K_JSR; count_next = 2'd0; do_push = 1'b1;
        end else if (md == M_IND) begin
          oaddr_next = full; o_addr = full; step_next = ST_PLO;
        end else if (md == M_ABX) begin do_access = 1'b1; acc_addr = full + {8'd0, x}; end
        else if (md == M_ABY) begin do_access = 1'b1; acc_addr = full + {8'd0, y}; end
        else begin do_access = 1'b1; acc_addr = full; end
      end
      ST_PLO: begin
        latch_next = d; o_addr = {oaddr[15:8], oaddr[7:0] + 8'd1}; step_next = ST_PHI;
      end
      ST_PHI: begin
        if (md == M_IND) begin pc_next = full; do_boundary = 1'b1; end
        else if (md == M_IZY) begin do_access = 1'b1; acc_addr = full + {8'd0, y}; end
        else begin do_access = 1'b1; acc_addr = full; end
      end
      ST_DATA: begin
        if (opc[4:0] == 5'h10) begin
          case (opc[7:6])
            2'd0: tst = p[7];
            2'd1: tst = p[6];
            2'd2: tst = p[0];
            default: tst = p[1];
          endcase
          if (tst == opc[5]) pc_next = pc + {{8{d[7]}}, d};
          do_boundary = 1'b1;
        end else if (opc[1:0] == 2'd2 && opc[7:5] != 3'd4 && opc[7:5] != 3'd5) begin
          sh = shift_op(opc[7:5], d, p);
          p_next = sh[15:8];
          o_addr = oaddr; o_we = 1'b1; o_data = sh[7:0]; step_next = ST_WEND;
        end else begin
          a_next = alu_a; x_next = alu_x; y_next = alu_y; p_next = alu_p;
          do_boundary = 1'b1;
        end
      end
      ST_WEND: do_boundary = 1'b1;
      ST_PUSH: begin
        if (seq_kind == K_JSR) begin
          if (seq_count < 2'd2) do_push = 1'b1;
          else begin pc_next = oaddr; do_boundary = 1'b1; end
        end else if (seq_count < 2'd3) begin
          do_push = 1'b1;
        end else begin
          p_next = p | PF_I;
          oaddr_next = (seq_kind == K_NMI) ? 16'hFFFA : 16'hFFFE;
          o_addr = oaddr_next; step_next = ST_VLO;
        end
      end
      ST_POP: begin
        if (opc == 8'h68) begin a_next = d; p_next = set_nz(p, d); do_boundary = 1'b1; end
        else if (opc == 8'h28) begin p_next = d; do_boundary = 1'b1; end
        else if (opc == 8'h60) begin
          if (seq_count == 2'd0) begin
            latch_next = d; count_next = 2'd1; sp_next = sp + 8'd1;
            o_addr = STACK_BASE | {8'd0, sp + 8'd1};
          end else begin
            pc_next = full + 16'd1; do_boundary = 1'b1;
          end
        end else begin
          if (seq_count == 2'd0) begin
            p_next = d; count_next = 2'd1; sp_next = sp + 8'd1;
            o_addr = STACK_BASE | {8'd0, sp + 8'd1};
          end else if (seq_count == 2'd1) begin
            latch_next = d; count_next = 2'd2; sp_next = sp + 8'd1;
            o_addr = STACK_BASE | {8'd0, sp + 8'd1};
          end else begin
            pc_next = full; do_boundary = 1'b1;
          end
        end
      end
      ST_PAD: begin
        kind_next = K_BRK; count_next = 2'd0; do_push = 1'b1;
      end
      default: begin
        stopped_next = 1'b1; o_addr = pc; step_next = ST_HALT;
      end
    endcase

    if (do_access) begin
      oaddr_next = acc_addr; o_addr = acc_addr;
      if (opc[7:5] == 3'd4) begin
        o_we = 1'b1; step_next = ST_WEND;
        o_data = (opc[1:0] == 2'd1) ? a : ((opc[1:0] == 2'd2) ? x : y);
      end else begin
        step_next = ST_DATA;
      end
    end

    // instruction boundary: nmi first, then irq against the updated I flag
    if (do_boundary) begin
      if (nmi_next) begin
        nmi_next = 1'b0; kind_next = K_NMI; count_next = 2'd0; do_push = 1'b1;
      end else if (irq_line && !p_next[2]) begin
        kind_next = K_IRQ; count_next = 2'd0; do_push = 1'b1;
      end else begin
        o_addr = pc_next; o_start = 1'b1; step_next = ST_OPC;
      end
    end

    if (do_push) begin
      if (count_next == 2'd0) pv = pc_next[15:8];
      else if (count_next == 2'd1) pv = pc_next[7:0];
      else if (kind_next == K_BRK) pv = p_next | PF_B;
      else pv = p_next & ~PF_B;
      count_next = count_next + 2'd1;
      o_addr = STACK_BASE | {8'd0, sp_next}; o_we = 1'b1; o_data = pv;
      sp_next = sp_next - 8'd1; step_next = ST_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= 8'd0; x <= 8'd0; y <= 8'd0; sp <= SP_RESET; p <= P_RESET;
      pc <= 16'd0; opc <= 8'd0; oaddr <= 16'd0; step <= ST_BOOT;
      nmi_pend <= 1'b0; stopped <= 1'b0; seq_kind <= K_BRK; seq_count <= 2'd0;
      latch <= 8'd0; out_valid <= 1'b0;
    end else begin
      if (accept) begin
        a <= a_next; x <= x_next; y <= y_next; sp <= sp_next; p <= p_next;
        pc <= pc_next; opc <= opc_next; oaddr <= oaddr_next; step <= step_next;
        nmi_pend <= nmi_next; stopped <= stopped_next; seq_kind <= kind_next;
        seq_count <= count_next; latch <= latch_next; out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bus_address <= o_addr; bus_write <= o_we; write_data <= o_data;
      instruction_start <= o_start; halted <= stopped_next;
    end
  end

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("halt cleared without reset");
  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !bus_write && !instruction_start)
    else $error("halted core issued a write or fetch");
  a_fetch_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && instruction_start |-> !bus_write) else $error("fetch marked as write");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(step)) else $error("sequencer moved while stalled");
`endif

endmodule
